FILE: sv/rcb_pkg.sv
// Shared constants, codes and handshake structs for the rod cutting revenue engine.
package rcb_pkg;

    // Default configuration of the engine.
    localparam int MAX_LEN_DEF     = 64;
    localparam int PRICE_WIDTH_DEF = 16;

    // Revenue word width and its saturation value.
    localparam int              REV_W   = 22;
    localparam logic [REV_W-1:0] REV_MAX = '1;

    // Input word layout, lowest field first.
    localparam int PIECE_W       = 7;
    localparam int PRICE_FIELD_W = 16;
    localparam int ROD_W         = 7;
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 24;

    // Kind of an input word, carried on tuser.
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_SOLVE = 1'b1
    } t_func;

    // Control from the top level to the solver.
    typedef struct packed {
        logic start;      // Begin a solve for the given length.
        logic out_ready;  // The output register can take a result this cycle.
    } t_solve_req;

    // Status from the solver to the top level.
    typedef struct packed {
        logic             idle;     // No solve in progress.
        logic             valid;    // A finished result is offered.
        logic [REV_W-1:0] revenue;  // Best revenue of the finished solve.
    } t_solve_rsp;

endpackage

FILE: sv/rcb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rcb_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/rcb_solver.sv
// Solve sequencer: walks the revenue table row by row and reduces one term per cycle.
module rcb_solver
    import rcb_pkg::*;
#(
    parameter  int MAX_LEN     = MAX_LEN_DEF,
    parameter  int PRICE_WIDTH = PRICE_WIDTH_DEF,
    localparam int LEN_W       = $clog2(MAX_LEN + 1),
    localparam int P_AW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_solve_req             i_req,
    input  logic [LEN_W-1:0]       i_n,
    output t_solve_rsp             o_rsp,
    output logic                   o_rd_en,
    output logic [P_AW-1:0]        o_price_raddr,
    output logic [LEN_W-1:0]       o_rev_raddr,
    input  logic [PRICE_WIDTH-1:0] i_price_rdata,
    input  logic [REV_W-1:0]       i_rev_rdata,
    output logic                   o_rev_we,
    output logic [LEN_W-1:0]       o_rev_waddr,
    output logic [REV_W-1:0]       o_rev_wdata
);

    localparam int SUM_W = ((PRICE_WIDTH > REV_W) ? PRICE_WIDTH : REV_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_i, n_i;
    logic [LEN_W-1:0] r_j, n_j;
    logic [LEN_W-1:0] r_n, n_n;
    logic [SUM_W-1:0] r_best, n_best;
    logic [REV_W-1:0] r_fwd, n_fwd;
    logic [REV_W-1:0] r_result, n_result;
    // Second stage: the term whose memory data arrives this cycle.
    logic             r_b_valid, n_b_valid;
    logic             r_b_last, n_b_last;
    logic             r_b_fwd, n_b_fwd;
    logic [LEN_W-1:0] r_b_i, n_b_i;

    logic [REV_W-1:0] rev_op;
    logic [SUM_W-1:0] cand;
    logic [SUM_W-1:0] mx;
    logic [REV_W-1:0] mx_sat;

    // The last term of a row pairs with r[0], which is zero. The first term
    // of a row reads the entry that the previous row writes in the same cycle, so it is forwarded.
    always_comb begin
        if (r_b_last) begin
            rev_op = '0;
        end else if (r_b_fwd) begin
            rev_op = r_fwd;
        end else begin
            rev_op = i_rev_rdata;
        end
        cand   = SUM_W'(i_price_rdata) + SUM_W'(rev_op);
        mx     = (cand > r_best) ? cand : r_best;
        mx_sat = (mx > SUM_W'(REV_MAX)) ? REV_MAX : mx[REV_W-1:0];
    end

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_n       = r_n;
        n_best    = r_best;
        n_fwd     = r_fwd;
        n_result  = r_result;
        n_b_valid = 1'b0;
        n_b_last  = r_b_last;
        n_b_fwd   = r_b_fwd;
        n_b_i     = r_b_i;

        if (r_b_valid) begin
            if (r_b_last) begin
                n_best   = '0;
                n_fwd    = mx_sat;
                n_result = mx_sat;
            end else begin
                n_best = mx;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_best = '0;
                    if (i_n == '0) begin
                        n_result = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_i     = LEN_W'(1);
                        n_j     = LEN_W'(1);
                        n_n     = i_n;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                n_b_valid = 1'b1;
                n_b_i     = r_i;
                n_b_last  = (r_j == r_i);
                n_b_fwd   = (r_j == LEN_W'(1));
                if (r_j == r_i) begin
                    if (r_i == r_n) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_i = r_i + LEN_W'(1);
                        n_j = LEN_W'(1);
                    end
                end else begin
                    n_j = r_j + LEN_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_req.out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_b_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_b_valid <= n_b_valid;
        end
        r_i      <= n_i;
        r_j      <= n_j;
        r_n      <= n_n;
        r_best   <= n_best;
        r_fwd    <= n_fwd;
        r_result <= n_result;
        r_b_last <= n_b_last;
        r_b_fwd  <= n_b_fwd;
        r_b_i    <= n_b_i;
    end

    assign o_rd_en       = (r_state == S_RUN);
    assign o_price_raddr = P_AW'(r_j - LEN_W'(1));
    assign o_rev_raddr   = r_i - r_j;
    assign o_rev_we      = r_b_valid && r_b_last;
    assign o_rev_waddr   = r_b_i;
    assign o_rev_wdata   = mx_sat;

    assign o_rsp.idle    = (r_state == S_IDLE);
    assign o_rsp.valid   = (r_state == S_DONE);
    assign o_rsp.revenue = r_result;

    a_wr_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rev_we |-> (o_rev_waddr != '0) && (o_rev_waddr <= r_n))
        else $error("revenue row written outside the current solve");

    a_run_ctr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_j != '0) && (r_j <= r_i) && (r_i <= r_n))
        else $error("row or term counter out of order");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == S_IDLE))
        else $error("solve started while busy");

    a_drain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> r_b_valid && r_b_last)
        else $error("drain without the final term in flight");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !i_req.out_ready) |=> o_rsp.valid && $stable(o_rsp.revenue))
        else $error("finished result dropped before it was taken");

endmodule

FILE: sv/rod_cut_bottom_up_top.sv
// Top level of the bottom-up rod cutting revenue engine.
//
// Usage: words enter on the slave stream (i_s_*). tuser selects the kind:
// a load word writes the price of one piece length into the price memory and
// gives no result; a load whose length is zero or above MAX_LEN is dropped.
// A solve word names a rod length (saturated to MAX_LEN) and gives one result
// word on the master stream (o_m_*) carrying the best revenue for that length.
// A solve fills the revenue table bottom up, one price-plus-revenue term per
// cycle, a rate set by the single read port of each memory; a length of zero
// skips the table. The block takes one word at a time: o_s_tready is high only
// while no solve is running.
// Results sit in an output register; while the receiver stalls, the block
// keeps taking words, and a following solve finishes into the register once
// it frees up. Reset (synchronous, active low) empties the output register and
// returns the sequencer to idle. Prices must be loaded before a solve reads
// them; the memories themselves are not cleared.
module rod_cut_bottom_up_top
    import rcb_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream.
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // tdata fields from bit 0: piece_length[6:0], price[22:7], rod_length[29:23],
    // zero fill [31:30].
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // tuser fields from bit 0: func (0 = load a price, 1 = solve).
    input  logic                   i_s_tuser,
    // Result stream.
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // tdata fields from bit 0: best_revenue[21:0], zero fill [23:22].
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int P_AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [PIECE_W-1:0]                   piece;
    logic [PRICE_FIELD_W-1:0]             price_in;
    logic [ROD_W-1:0]                     rod;
    logic [PRICE_FIELD_W+PRICE_WIDTH-1:0] price_ext;
    logic                                 in_take;
    logic                                 piece_ok;
    logic                                 price_we;
    logic [P_AW-1:0]                      price_waddr;
    logic [LEN_W-1:0]                     solve_n;

    t_solve_req       req;
    t_solve_rsp       rsp;
    logic             rd_en;
    logic [P_AW-1:0]  price_raddr;
    logic [LEN_W-1:0] rev_raddr;
    logic [PRICE_WIDTH-1:0] price_rdata;
    logic [REV_W-1:0] rev_rdata;
    logic             rev_we;
    logic [LEN_W-1:0] rev_waddr;
    logic [REV_W-1:0] rev_wdata;

    logic             r_out_valid;
    logic [REV_W-1:0] r_out_data;
    logic             out_free;

    // Unpack the input word.
    assign piece    = i_s_tdata[PIECE_W-1:0];
    assign price_in = i_s_tdata[PIECE_W +: PRICE_FIELD_W];
    assign rod      = i_s_tdata[PIECE_W+PRICE_FIELD_W +: ROD_W];

    assign o_s_tready = rsp.idle;
    assign in_take    = i_s_tvalid && o_s_tready;

    // Loads keep only the low PRICE_WIDTH bits of the price.
    assign price_ext   = {{PRICE_WIDTH{1'b0}}, price_in};
    assign piece_ok    = (piece != '0) && (32'(piece) <= MAX_LEN);
    assign price_we    = in_take && (t_func'(i_s_tuser) == FUNC_LOAD) && piece_ok;
    assign price_waddr = P_AW'(32'(piece) - 32'd1);

    // Rod lengths beyond the table saturate to its last row.
    assign solve_n = (32'(rod) > MAX_LEN) ? LEN_W'(MAX_LEN) : LEN_W'(rod);

    // The output register can take a result when empty or being drained.
    assign out_free      = !r_out_valid || i_m_tready;
    assign req.start     = in_take && (t_func'(i_s_tuser) == FUNC_SOLVE);
    assign req.out_ready = out_free;

    rcb_ram #(
        .WIDTH (PRICE_WIDTH),
        .DEPTH (MAX_LEN)
    ) u_price_ram (
        .i_clk   (i_clk),
        .i_we    (price_we),
        .i_waddr (price_waddr),
        .i_wdata (price_ext[PRICE_WIDTH-1:0]),
        .i_re    (rd_en),
        .i_raddr (price_raddr),
        .o_rdata (price_rdata)
    );

    rcb_ram #(
        .WIDTH (REV_W),
        .DEPTH (MAX_LEN + 1)
    ) u_rev_ram (
        .i_clk   (i_clk),
        .i_we    (rev_we),
        .i_waddr (rev_waddr),
        .i_wdata (rev_wdata),
        .i_re    (rd_en),
        .i_raddr (rev_raddr),
        .o_rdata (rev_rdata)
    );

    rcb_solver #(
        .MAX_LEN     (MAX_LEN),
        .PRICE_WIDTH (PRICE_WIDTH)
    ) u_solver (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_n           (solve_n),
        .o_rsp         (rsp),
        .o_rd_en       (rd_en),
        .o_price_raddr (price_raddr),
        .o_rev_raddr   (rev_raddr),
        .i_price_rdata (price_rdata),
        .i_rev_rdata   (rev_rdata),
        .o_rev_we      (rev_we),
        .o_rev_waddr   (rev_waddr),
        .o_rev_wdata   (rev_wdata)
    );

    // Output register: holds one result word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp.valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (rsp.valid && out_free) begin
            r_out_data <= rsp.revenue;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W-REV_W){1'b0}}, r_out_data};

endmodule
